/* sv/jrma_pkg.sv */
// ----------------------------------------------------------------------------
// jrma_pkg: shared definitions for the jump-reset moving average
// Field widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package jrma_pkg;

    // Payload field widths.
    localparam int SAMPLE_W = 32;
    localparam int TICK_W   = 32;
    localparam int THR_W    = 16;
    localparam int INTV_W   = 31;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_INTERVAL  = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0]  RST_JUMP_THRESHOLD = THR_W'(26);
    localparam logic [INTV_W-1:0] RST_SHOW_INTERVAL  = INTV_W'(100);

    // Default window length.
    localparam int DEF_WINDOW_DEPTH = 16;

    // Sequencer states for one item.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DECIDE,
        S_UPDATE,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

endpackage

/* sv/jump_reset_moving_average.sv */
// ----------------------------------------------------------------------------
// jump_reset_moving_average: moving average that restarts on a jump
// Keeps the latest samples in a ring RAM with a running sum, empties the
// window when a sample strays too far from the average, and flags when a
// new display point is due.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Bits                       Contents
//  s_axis    in         tdata[63:0]                sample [31:0], tick [63:32]
//  m_axis    out        tdata[31:0], tuser[1:0]    average; show [0], restarted [1]
//  cfg       in         idx[1:0], data[30:0]       0 jump_threshold, 1 show_interval
//
//  An item passes through the test, decide, update, prep, divide and output
//  states after acceptance. The bit-serial divider forms sum / count, one
//  quotient bit per cycle over the running-sum width. The input is accepted
//  again once the result has moved into the output register, so a result
//  may wait on the output while the next item is processed. A stalled
//  output holds the sequencer in its final state. Reset is synchronous and
//  clears the window, the average, the last display tick and the registers
//  to their default values.
//
module jump_reset_moving_average
    import jrma_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [63:0]           i_s_tdata,   // sample [31:0], tick [63:32]
    // Result items.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [31:0]           o_m_tdata,   // average [31:0]
    output logic [1:0]            o_m_tuser,   // show [0], restarted [1]
    // Configuration writes.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int DCNT_W = $clog2(SUM_W);
    localparam int PROD_W = THR_W + 1 + SAMPLE_W;
    localparam int CMP_W  = PROD_W + 1;
    localparam int MAG_W  = SAMPLE_W + 1;

    localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_DEPTH);
    localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(SUM_W - 1);

    // Configuration registers.
    logic [THR_W-1:0]  r_threshold;
    logic [INTV_W-1:0] r_interval;

    // Window state.
    logic [IDX_W-1:0]        r_wslot;
    logic [IDX_W-1:0]        r_oslot;
    logic [CNT_W-1:0]        r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SAMPLE_W-1:0] r_avg;
    logic [TICK_W-1:0]       r_last_tick;

    // Item being worked on.
    t_state                     r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [TICK_W-1:0]          r_tick;
    logic signed [PROD_W-1:0]   r_prod;
    logic [MAG_W+7:0]           r_mag_sh;
    logic                       r_restart;

    // Divider.
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic              r_neg;
    logic [DCNT_W-1:0] r_div_cnt;

    // Output register.
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_avg;
    logic                r_out_show;
    logic                r_out_restart;

    // Control from the output decode.
    logic ram_we;
    logic out_free;
    logic out_load;
    logic in_accept;

    logic signed [SAMPLE_W-1:0] ram_rdata;

    // ------------------------------------------------------------------
    // Datapath helpers.
    // ------------------------------------------------------------------
    logic signed [MAG_W-1:0] dev;
    logic [MAG_W-1:0]        mag;
    logic                    jump;
    logic                    full;
    logic signed [SUM_W-1:0] sum_drop;
    logic signed [SUM_W-1:0] sum_next;
    logic [CNT_W:0]          rem_sh;
    logic                    rem_ge;
    logic [CNT_W:0]          rem_sub;
    logic [SUM_W-1:0]        quo_signed;
    logic [TICK_W-1:0]       elapsed;
    logic                    show;

    always_comb begin
        dev  = MAG_W'(r_sample) - MAG_W'(r_avg);
        mag  = dev[MAG_W-1] ? MAG_W'(-dev) : MAG_W'(dev);
        // Deviation times 256 against threshold times average, both exact.
        jump = $signed({{(CMP_W - MAG_W - 8){1'b0}}, r_mag_sh})
               > $signed({r_prod[PROD_W-1], r_prod});
        full = (r_count == FULL_CNT);
        sum_drop = full ? SUM_W'(ram_rdata) : '0;
        sum_next = r_sum - sum_drop + SUM_W'(r_sample);
        rem_sh   = {r_rem, r_quo[SUM_W-1]};
        rem_sub  = rem_sh - {1'b0, r_count};
        rem_ge   = (rem_sh >= {1'b0, r_count});
        quo_signed = r_neg ? SUM_W'(-r_quo) : r_quo;
        elapsed  = r_tick - r_last_tick;
        show     = !elapsed[TICK_W-1] && (elapsed[INTV_W-1:0] > r_interval);
    end

    // Sample ring.
    jrma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata (r_sample),
        .i_raddr (r_oslot),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_TEST;
            S_TEST:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_UPDATE;
            S_UPDATE: n_state = S_PREP;
            S_PREP:   n_state = S_DIV;
            S_DIV:    if (r_div_cnt == DIV_LAST) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        case (r_state)
            S_IDLE:   o_s_tready = 1'b1;
            S_UPDATE: ram_we     = 1'b1;
            default: begin
                o_s_tready = 1'b0;
                ram_we     = 1'b0;
            end
        endcase
    end

    assign in_accept = i_s_tvalid && o_s_tready;
    assign out_free  = !r_out_valid || i_m_tready;
    assign out_load  = (r_state == S_OUT) && out_free;

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= RST_JUMP_THRESHOLD;
            r_interval  <= RST_SHOW_INTERVAL;
            r_wslot     <= '0;
            r_oslot     <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_avg       <= '0;
            r_last_tick <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Register writes; an index beyond the list is ignored.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_JUMP_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                    REG_SHOW_INTERVAL:  r_interval  <= i_cfg_data[INTV_W-1:0];
                    default: ;
                endcase
            end

            // Empty the window when the jump test fires.
            if (r_state == S_DECIDE && jump) begin
                r_wslot <= '0;
                r_oslot <= '0;
                r_count <= '0;
                r_sum   <= '0;
            end

            // Drop the oldest sample if full, then append the new one.
            if (r_state == S_UPDATE) begin
                r_sum   <= sum_next;
                r_wslot <= (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
                if (full) begin
                    r_oslot <= (r_oslot == LAST_SLOT) ? '0 : r_oslot + 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end

            // Hand the result over and keep the average for the next test.
            if (out_load) begin
                r_avg <= quo_signed[SAMPLE_W-1:0];
                if (show) begin
                    r_last_tick <= r_tick;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_s_tdata[SAMPLE_W-1:0];
            r_tick   <= i_s_tdata[SAMPLE_W +: TICK_W];
        end

        // Jump test operands.
        if (r_state == S_TEST) begin
            r_prod   <= PROD_W'($signed({1'b0, r_threshold})) * PROD_W'(r_avg);
            r_mag_sh <= {mag, 8'd0};
        end

        if (r_state == S_DECIDE) begin
            r_restart <= jump && (r_count != '0);
        end

        // Divider load: magnitude of the sum, sign kept apart.
        if (r_state == S_PREP) begin
            r_neg     <= r_sum[SUM_W-1];
            r_quo     <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end

        // One restoring step per cycle.
        if (r_state == S_DIV) begin
            r_rem     <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_quo     <= {r_quo[SUM_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + 1'b1;
        end

        if (out_load) begin
            r_out_avg     <= quo_signed[SAMPLE_W-1:0];
            r_out_show    <= show;
            r_out_restart <= r_restart;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_avg;
    assign o_m_tuser  = {r_out_restart, r_out_show};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("window count exceeds its depth");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count != '0))
        else $error("division by an empty window");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result offered without a finished item");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_TEST))
        else $error("accepted item did not start the test");

endmodule

/* sv/jrma_ram.sv */
// ----------------------------------------------------------------------------
// jrma_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module jrma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/sv/tb_jump_reset_moving_average.sv */
// ----------------------------------------------------------------------------
// tb_jump_reset_moving_average: self-checking bench for the jump-reset average
// A behavioural model in a small scoreboard class tracks the sample window,
// the running sum and the last display tick, and predicts the average, the
// show flag and the restart flag of every accepted item. Stimulus is a short
// directed run over the corner cases followed by bursts of samples around a
// chosen level, with full-range noise, under several register settings and
// with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_jump_reset_moving_average;
    import jrma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_LEN = DEF_WINDOW_DEPTH;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASE_ITEMS = 190;

    // Register indexes that decode to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef struct packed {
        logic [31:0] average;
        logic        show;
        logic        restarted;
    } t_avg_result;

    // Window model and queue of averages still to come out of the block.
    class t_avg_scoreboard;
        logic signed [31:0] win [WIN_LEN];
        int                 win_wr;
        int                 win_rd;
        int                 win_len;
        longint             win_sum;
        logic [31:0]        shown_at;
        logic [THR_W-1:0]   jump_thr;
        logic [INTV_W-1:0]  show_gap;
        t_avg_result        due_averages [$];
        int                 fails;

        function new();
            foreach (win[k]) win[k] = '0;
            win_wr   = 0;
            win_rd   = 0;
            win_len  = 0;
            win_sum  = 0;
            shown_at = '0;
            jump_thr = RST_JUMP_THRESHOLD;
            show_gap = RST_SHOW_INTERVAL;
            fails    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_JUMP_THRESHOLD) begin
                jump_thr = data[THR_W-1:0];
            end else if (idx == REG_SHOW_INTERVAL) begin
                show_gap = data[INTV_W-1:0];
            end
        endfunction

        // Advances the window by one accepted sample and queues its result.
        function void note_sample(logic [31:0] smp_bits, logic [31:0] tk);
            longint      smp;
            longint      old_avg;
            longint      dev;
            longint      mag;
            longint      new_avg;
            logic [31:0] elapsed;
            t_avg_result r;
            smp = $signed(smp_bits);
            old_avg = (win_len == 0) ? 0 : win_sum / win_len;
            dev = smp - old_avg;
            mag = (dev < 0) ? -dev : dev;
            r.restarted = 1'b0;
            // The jump test compares the deviation with a Q8.8 fraction of the average.
            if (mag * 256 > longint'(jump_thr) * old_avg) begin
                r.restarted = (win_len != 0);
                win_wr  = 0;
                win_rd  = 0;
                win_len = 0;
                win_sum = 0;
            end
            if (win_len >= WIN_LEN) begin
                win_sum -= win[win_rd];
                win_rd  = (win_rd + 1) % WIN_LEN;
                win_len = WIN_LEN - 1;
            end
            win[win_wr] = smp_bits;
            win_wr  = (win_wr + 1) % WIN_LEN;
            win_sum += smp;
            win_len++;
            new_avg = win_sum / win_len;
            // A tick that has gone backwards reads as negative and never shows.
            elapsed = tk - shown_at;
            r.show = !elapsed[31] && (elapsed > {1'b0, show_gap});
            if (r.show) shown_at = tk;
            r.average = new_avg[31:0];
            due_averages.push_back(r);
        endfunction

        function void check_result(logic [31:0] avg, logic show, logic restarted);
            t_avg_result exp_r;
            if (due_averages.size() == 0) begin
                $error("result with no item pending: average %0d", $signed(avg));
                fails++;
                return;
            end
            exp_r = due_averages.pop_front();
            if (avg !== exp_r.average) begin
                $error("average: expected %0d, actual %0d",
                       $signed(exp_r.average), $signed(avg));
                fails++;
            end
            if (show !== exp_r.show) begin
                $error("show: expected %0b, actual %0b", exp_r.show, show);
                fails++;
            end
            if (restarted !== exp_r.restarted) begin
                $error("restarted: expected %0b, actual %0b", exp_r.restarted, restarted);
                fails++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [63:0]           i_s_tdata = '0;    // sample [31:0], tick [63:32]
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [31:0]           o_m_tdata;         // average [31:0]
    logic [1:0]            o_m_tuser;         // show [0], restarted [1]
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_avg_scoreboard sb = new();
    bit            steady = 1'b0;
    int            cycles = 0;
    logic [31:0]   tick_now = '0;

    jump_reset_moving_average uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 2 ns period.
    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Input monitor: every accepted item advances the model.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_sample(i_s_tdata[31:0], i_s_tdata[63:32]);
        end
    end

    // Result side: random back-pressure and checking of accepted items.
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= 16);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata, o_m_tuser[0], o_m_tuser[1]);
        end
    end

    // Offers one item after a random gap and returns at the edge that takes it.
    task automatic send_item(input logic [31:0] smp, input logic [31:0] tk);
        while (!steady && $urandom_range(0, 99) < 16) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {tk, smp};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Waits for every pending result, then lets the block settle. The first
    // edge lets the monitor note the item taken at the previous edge.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_averages.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly a steady clock, sometimes a wild jump or a step backwards.
    task automatic next_tick();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) tick_now = $urandom();
        else if (pick < 6) tick_now = tick_now - $urandom_range(1, 200);
        else tick_now = tick_now + $urandom_range(0, 40);
    endtask

    // Bursts of samples around a level, with some full-range noise between.
    task automatic run_bursts(input int n_items);
        longint level;
        longint span;
        longint smp;
        int     left;
        left  = 0;
        level = 0;
        span  = 0;
        for (int i = 0; i < n_items; i++) begin
            if (left == 0 || $urandom_range(0, 99) < 4) begin
                case ($urandom_range(0, 7))
                    0:       level = 0;
                    1:       level = $urandom_range(1, 4096);
                    5:       level = -longint'($urandom_range(1, 32'h3FFF_FFFF));
                    6:       level = longint'(32'h7FFF_FFFF) - $urandom_range(0, 1000);
                    7:       level = longint'($signed($urandom()));
                    default: level = $urandom_range(65536, 32'h3FFF_FFFF);
                endcase
                span = (level < 0 ? -level : level) / 200;
                if ($urandom_range(0, 3) == 0) span = 0;
                left = $urandom_range(4, 40);
            end
            left--;
            if ($urandom_range(0, 99) < 8) begin
                smp = longint'($signed($urandom()));
            end else begin
                smp = level + longint'($urandom_range(0, 32'(2 * span))) - span;
                if (smp > 64'sh7FFF_FFFF || smp < -64'sh8000_0000) smp = level;
            end
            next_tick();
            send_item(smp[31:0], tick_now);
        end
    endtask

    initial begin
        logic [31:0] rnd_thr;
        logic [31:0] rnd_intv;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty window, full-scale samples, negative averages.
        send_item(32'h0000_0000, 32'd0);
        send_item(32'h7FFF_FFFF, 32'd50);
        send_item(32'h7FFF_FFFF, 32'd101);
        send_item(32'h7FFF_FFFE, 32'd150);
        send_item(32'h8000_0000, 32'd100);
        send_item(32'h8000_0000, 32'd202);
        send_item(32'hFFFF_FFFF, 32'd303);
        // Enough equal samples to fill the window and make it wrap.
        tick_now = 32'd310;
        for (int i = 0; i < WIN_LEN + 1; i++) begin
            tick_now = tick_now + 32'd17;
            send_item(32'h0001_0000, tick_now);
        end
        drain();

        // Unit threshold given with stray upper bits, interval zero so any forward tick shows.
        cfg_write(REG_JUMP_THRESHOLD, 31'h7FFF_0100);
        cfg_write(REG_SHOW_INTERVAL, '0);
        cfg_write(REG_SPARE_2, 31'h5555_5555);
        run_bursts(PHASE_ITEMS);
        drain();

        // Zero threshold: a negative average survives only an equal sample.
        cfg_write(REG_JUMP_THRESHOLD, '0);
        cfg_write(REG_SHOW_INTERVAL, 31'h7FFF_FFFF);
        send_item(32'hFFFB_0000, tick_now);
        send_item(32'hFFFB_0000, tick_now + 32'd1);
        send_item(32'hFFFB_0000, tick_now + 32'd2);
        tick_now = tick_now + 32'd2;
        run_bursts(PHASE_ITEMS);
        drain();

        // Widest threshold, short interval, no idling on either side.
        steady = 1'b1;
        cfg_write(REG_JUMP_THRESHOLD, 31'h0000_FFFF);
        cfg_write(REG_SHOW_INTERVAL, 31'd5);
        cfg_write(REG_SPARE_3, 31'h2AAA_AAAA);
        run_bursts(PHASE_ITEMS);
        drain();
        steady = 1'b0;

        cfg_write(REG_JUMP_THRESHOLD, 31'd3);
        cfg_write(REG_SHOW_INTERVAL, 31'd1000);
        run_bursts(PHASE_ITEMS);
        drain();

        rnd_thr  = $urandom();
        rnd_intv = $urandom_range(0, 300);
        cfg_write(REG_JUMP_THRESHOLD, rnd_thr[CFG_DATA_W-1:0]);
        cfg_write(REG_SHOW_INTERVAL, rnd_intv[CFG_DATA_W-1:0]);
        run_bursts(PHASE_ITEMS);
        drain();

        // Back to the reset settings.
        cfg_write(REG_JUMP_THRESHOLD, CFG_DATA_W'(RST_JUMP_THRESHOLD));
        cfg_write(REG_SHOW_INTERVAL, CFG_DATA_W'(RST_SHOW_INTERVAL));
        run_bursts(PHASE_ITEMS);
        drain();

        if (sb.fails == 0 && sb.due_averages.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* jump_reset_moving_average.f */
sv/jrma_pkg.sv
sv/jrma_ram.sv
sv/jump_reset_moving_average.sv
tb/sv/tb_jump_reset_moving_average.sv
